[hdl/delta_list_task_scheduler_defines.svh]
// assertion macros shared by the scheduler checker
`ifndef DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define DLTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/dlts_pkg.sv]
// shared types and constants of the delta-list task scheduler
package dlts_pkg;

  // request kinds carried on s_tuser
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_ADD      = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;
  localparam logic [1:0] REQ_NOP      = 2'd3;

  // fixed field widths
  localparam int REQ_W      = 2;
  localparam int TASK_W     = 8;
  localparam int FIELD_DLY_W = 16;
  localparam int POS_W      = 5;
  localparam int OCC_W      = 5;
  localparam int DUE_W      = 8;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;
  localparam int M_PAD_W    = M_TDATA_W - (1 + POS_W + 1 + TASK_W + OCC_W);

  // per-cell operation
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_DEC,
    OP_LOAD,
    OP_FROM_LEFT,
    OP_FROM_LEFT_SUB,
    OP_FROM_RIGHT,
    OP_FROM_RIGHT_ADD
  } cell_op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_t;

endpackage

[hdl/dlts_cell.sv]
// one queue slot: task, relative delay and period, shifting to either neighbor
module dlts_cell
  import dlts_pkg::*;
#(
  parameter int DW = 16
) (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [TASK_W-1:0] new_task,
  input  logic [DW-1:0]     new_delta,
  input  logic [DW-1:0]     new_period,
  input  logic [TASK_W-1:0] left_task,
  input  logic [DW-1:0]     left_delta,
  input  logic [DW-1:0]     left_period,
  input  logic [TASK_W-1:0] right_task,
  input  logic [DW-1:0]     right_delta,
  input  logic [DW-1:0]     right_period,
  output logic [TASK_W-1:0] task_q,
  output logic [DW-1:0]     delta_q,
  output logic [DW-1:0]     period_q
);

  logic [TASK_W-1:0] task_next;
  logic [DW-1:0]     delta_next;
  logic [DW-1:0]     period_next;
  logic [DW:0]       merge_sum;

  // merged delay of a popped head and its successor, saturating
  assign merge_sum = {1'b0, right_delta} + {1'b0, delta_q};

  // slot update
  always_comb begin
    task_next   = task_q;
    delta_next  = delta_q;
    period_next = period_q;
    unique case (op)
      OP_HOLD: begin
      end
      OP_DEC: begin
        delta_next = delta_q - 1'b1;
      end
      OP_LOAD: begin
        task_next   = new_task;
        delta_next  = new_delta;
        period_next = new_period;
      end
      OP_FROM_LEFT: begin
        task_next   = left_task;
        delta_next  = left_delta;
        period_next = left_period;
      end
      OP_FROM_LEFT_SUB: begin
        task_next   = left_task;
        delta_next  = left_delta - new_delta;
        period_next = left_period;
      end
      OP_FROM_RIGHT: begin
        task_next   = right_task;
        delta_next  = right_delta;
        period_next = right_period;
      end
      OP_FROM_RIGHT_ADD: begin
        task_next   = right_task;
        delta_next  = merge_sum[DW] ? {DW{1'b1}} : merge_sum[DW-1:0];
        period_next = right_period;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    task_q   <= task_next;
    delta_q  <= delta_next;
    period_q <= period_next;
  end

endmodule

[hdl/delta_list_task_scheduler.sv]
// delta-list task scheduler: sequencer over a row of queue slot cells
// tick, no-op, full add and one-shot dispatch pass from idle straight to the result state;
// add and periodic dispatch first walk over k entries (0..QUEUE_DEPTH-1), then insert,
// one slot compared per cycle by the shared walk comparator; a shift moves the whole row at once.
// one request in flight; s_tready rises on the same edge that registers the result.
// rst clears queue count, due count, sequencer and output valid; slot contents are not reset.
module delta_list_task_scheduler
  import dlts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DELAY_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // task_id [7:0], delay [23:8], period [39:24]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // req_type [1:0]
  input  logic [REQ_W-1:0]     s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // accepted [0], position [5:1], fired [6], fired_task [14:7], occupancy [19:15], zero pad
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DW    = DELAY_WIDTH;

  // request fields
  logic [REQ_W-1:0]  in_req;
  logic [TASK_W-1:0] in_task;
  logic [DW-1:0]     in_delay;
  logic [DW-1:0]     in_period;

  assign in_req    = s_tuser;
  assign in_task   = s_tdata[TASK_W-1:0];
  assign in_delay  = DW'(s_tdata[TASK_W +: FIELD_DLY_W]);
  assign in_period = DW'(s_tdata[TASK_W + FIELD_DLY_W +: FIELD_DLY_W]);

  // sequencer registers
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [DUE_W-1:0]  due, due_next;
  logic [IDX_W-1:0]  walk_idx, walk_idx_next;
  logic [DW-1:0]     rem, rem_next;
  logic [TASK_W-1:0] ins_task, ins_task_next;
  logic [DW-1:0]     ins_period, ins_period_next;
  logic              walk_is_add, walk_is_add_next;
  logic              res_accepted, res_accepted_next;
  logic [IDX_W-1:0]  res_position, res_position_next;
  logic              res_fired, res_fired_next;
  logic [TASK_W-1:0] res_fired_task, res_fired_task_next;

  // cell row
  cell_op_t          cell_op     [QUEUE_DEPTH];
  logic [TASK_W-1:0] cell_task   [QUEUE_DEPTH];
  logic [DW-1:0]     cell_delta  [QUEUE_DEPTH];
  logic [DW-1:0]     cell_period [QUEUE_DEPTH];

  // decisions shared by next-state and datapath logic
  logic req_fire;
  logic add_go;
  logic disp_go;
  logic disp_reinsert;
  logic walk_more;
  logic out_free;
  logic [DW-1:0] cur_delta;

  assign req_fire      = s_tvalid && s_tready;
  assign add_go        = (in_req == REQ_ADD) && (count < CNT_W'(QUEUE_DEPTH));
  assign disp_go       = (in_req == REQ_DISPATCH) && (count != '0) && (due != '0);
  assign disp_reinsert = cell_period[0] != '0;
  assign cur_delta     = cell_delta[walk_idx];
  assign walk_more     = (CNT_W'(walk_idx) < count) && (cur_delta <= rem);
  assign out_free      = !m_tvalid || m_tready;
  assign s_tready      = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (add_go || (disp_go && disp_reinsert)) begin
            state_next = ST_WALK;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_WALK: begin
        if (!walk_more) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath control and cell operations
  always_comb begin
    count_next          = count;
    due_next            = due;
    walk_idx_next       = walk_idx;
    rem_next            = rem;
    ins_task_next       = ins_task;
    ins_period_next     = ins_period;
    walk_is_add_next    = walk_is_add;
    res_accepted_next   = res_accepted;
    res_position_next   = res_position;
    res_fired_next      = res_fired;
    res_fired_task_next = res_fired_task;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      cell_op[j] = OP_HOLD;
    end
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          res_accepted_next   = 1'b0;
          res_position_next   = '0;
          res_fired_next      = 1'b0;
          res_fired_task_next = '0;
          walk_idx_next       = '0;
          unique case (in_req)
            REQ_TICK: begin
              if (count != '0) begin
                if (cell_delta[0] == '0) begin
                  if (due != {DUE_W{1'b1}}) begin
                    due_next = due + 1'b1;
                  end
                end else begin
                  cell_op[0] = OP_DEC;
                end
              end
            end
            REQ_ADD: begin
              rem_next         = in_delay;
              ins_task_next    = in_task;
              ins_period_next  = in_period;
              walk_is_add_next = 1'b1;
            end
            REQ_DISPATCH: begin
              if (disp_go) begin
                res_fired_next      = 1'b1;
                res_fired_task_next = cell_task[0];
                rem_next            = cell_period[0];
                ins_task_next       = cell_task[0];
                ins_period_next     = cell_period[0];
                walk_is_add_next    = 1'b0;
                count_next          = count - 1'b1;
                due_next            = '0;
                // pop: every slot takes its right neighbor, head merges delays
                cell_op[0] = OP_FROM_RIGHT_ADD;
                for (int j = 1; j < QUEUE_DEPTH; j++) begin
                  cell_op[j] = OP_FROM_RIGHT;
                end
              end
            end
            REQ_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_more) begin
          rem_next      = rem - cur_delta;
          walk_idx_next = walk_idx + 1'b1;
        end else begin
          // insert: open a hole at walk_idx, trim the following slot's delay
          for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (j == int'(walk_idx)) begin
              cell_op[j] = OP_LOAD;
            end else if (j == int'(walk_idx) + 1) begin
              cell_op[j] = (CNT_W'(walk_idx) < count) ? OP_FROM_LEFT_SUB : OP_HOLD;
            end else if (j > int'(walk_idx) + 1) begin
              cell_op[j] = OP_FROM_LEFT;
            end
          end
          if (walk_idx == '0) begin
            due_next = '0;
          end
          count_next = count + 1'b1;
          if (walk_is_add) begin
            res_accepted_next = 1'b1;
            res_position_next = walk_idx;
          end
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // slot cells
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic [TASK_W-1:0] l_task, r_task;
    logic [DW-1:0]     l_delta, r_delta, l_period, r_period;

    if (g == 0) begin : g_left_edge
      assign l_task   = '0;
      assign l_delta  = '0;
      assign l_period = '0;
    end else begin : g_left
      assign l_task   = cell_task[g-1];
      assign l_delta  = cell_delta[g-1];
      assign l_period = cell_period[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_right_edge
      assign r_task   = '0;
      assign r_delta  = '0;
      assign r_period = '0;
    end else begin : g_right
      assign r_task   = cell_task[g+1];
      assign r_delta  = cell_delta[g+1];
      assign r_period = cell_period[g+1];
    end

    dlts_cell #(
      .DW(DW)
    ) u_cell (
      .clk         (clk),
      .op          (cell_op[g]),
      .new_task    (ins_task),
      .new_delta   (rem),
      .new_period  (ins_period),
      .left_task   (l_task),
      .left_delta  (l_delta),
      .left_period (l_period),
      .right_task  (r_task),
      .right_delta (r_delta),
      .right_period(r_period),
      .task_q      (cell_task[g]),
      .delta_q     (cell_delta[g]),
      .period_q    (cell_period[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      due   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      due   <= due_next;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    walk_idx       <= walk_idx_next;
    rem            <= rem_next;
    ins_task       <= ins_task_next;
    ins_period     <= ins_period_next;
    walk_is_add    <= walk_is_add_next;
    res_accepted   <= res_accepted_next;
    res_position   <= res_position_next;
    res_fired      <= res_fired_next;
    res_fired_task <= res_fired_task_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {{M_PAD_W{1'b0}}, OCC_W'(count), res_fired_task, res_fired,
                  POS_W'(res_position), res_accepted};
    end
  end

endmodule

[hdl/dlts_checker.sv]
// port-level checks for the delta-list task scheduler, bound to the top level
`include "delta_list_task_scheduler_defines.svh"

module dlts_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // a stalled result holds
  `DLTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // one request at a time: busy right after a request is taken
  `DLTS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // an add and a dispatch release never share a result
  `DLTS_ASSERT_NOW(a_excl, m_tvalid, !(m_tdata[0] && m_tdata[6]), "accepted and fired both set")

  // position reads zero unless an add was stored
  `DLTS_ASSERT_NOW(a_pos_zero, m_tvalid && !m_tdata[0], m_tdata[5:1] == 5'd0, "stray position")

  // occupancy never exceeds the queue depth
  `DLTS_ASSERT_NOW(a_occ_range, m_tvalid, m_tdata[19:15] <= QUEUE_DEPTH, "occupancy out of range")

endmodule

bind delta_list_task_scheduler dlts_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_dlts_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
